@@ hw/rtl/multi_click_gesture_detector_assert.svh @@
// ----------------------------------------------------------------------------
// Multi-click gesture detector assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MULTI_CLICK_GESTURE_DETECTOR_ASSERT_SVH
`define MULTI_CLICK_GESTURE_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCGD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("multi_click_gesture_detector: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MCGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("multi_click_gesture_detector: next-cycle check failed");

`endif

@@ hw/rtl/mcgd_pkg.sv @@
// ----------------------------------------------------------------------------
// Multi-click gesture detector package
// Register indexes, reset values and result codes of the gesture detector.
// ----------------------------------------------------------------------------
package mcgd_pkg;

    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int COUNT_BITS     = 8;
    localparam int THRESHOLD_BITS = 12;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    typedef logic [2:0]              t_gesture;
    typedef logic [COUNT_BITS-1:0]   t_count;

    localparam t_cfg_idx CFG_FLEX_THRESHOLD  = 2'd0;
    localparam t_cfg_idx CFG_DEBOUNCE_MS     = 2'd1;
    localparam t_cfg_idx CFG_WINDOW_MS       = 2'd2;
    localparam t_cfg_idx CFG_SUSTAIN_SAMPLES = 2'd3;

    localparam logic [15:0] RST_FLEX_THRESHOLD  = 16'd2048;
    localparam logic [15:0] RST_DEBOUNCE_MS     = 16'd200;
    localparam logic [15:0] RST_WINDOW_MS       = 16'd600;
    localparam t_count      RST_SUSTAIN_SAMPLES = 8'd6;

    localparam t_gesture GESTURE_NONE = 3'd0;
    localparam t_gesture GESTURE_QUAD = 3'd4;

    localparam t_count COUNT_MAX = 8'hFF;

endpackage

@@ hw/rtl/multi_click_gesture_detector.sv @@
// ----------------------------------------------------------------------------
// Multi-click gesture detector
// When not stalled, the block takes one sample beat per clock cycle and
// returns one result beat for each. Every input beat is processed in the cycle
// in which it is accepted: the flex average adder, the elapsed-time subtractor
// and its compares against the debounce and window times sit between the input
// port and the result register, so the sustained rate is one beat per cycle.
// The result register frees itself when its beat is taken, so a new
// sample is accepted in the same cycle as the previous result leaves. A falling
// button edge, or a sensor signal held for the sustain count after the debounce
// time, counts a click; once the window time has passed quietly since the last
// click, the count is reported as single, double, triple or quad and cleared.
// ----------------------------------------------------------------------------
`include "multi_click_gesture_detector_assert.svh"

module multi_click_gesture_detector #(
    parameter int ADC_BITS  = 12,
    parameter int TIME_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_we,
    input  mcgd_pkg::t_cfg_idx                i_cfg_idx,
    input  logic [mcgd_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // button_level, ir_level, flex_sample, now_ms; zero padding on top
    input  logic [((2+ADC_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // live_click, gesture, live_count; zero padding on top
    output logic [15:0]                       m_axis_tdata
);

    localparam int SUM_BITS = ADC_BITS + 2;
    localparam int THR_BITS = mcgd_pkg::THRESHOLD_BITS;
    localparam int CMP_BITS = (ADC_BITS > THR_BITS) ? ADC_BITS : THR_BITS;

    logic [THR_BITS-1:0]      r_flex_threshold;
    logic [15:0]              r_debounce_ms;
    logic [15:0]              r_window_ms;
    mcgd_pkg::t_count         r_sustain_samples;

    logic                     r_button_prev;
    logic [ADC_BITS-1:0]      r_flex_avg;
    mcgd_pkg::t_count         r_run;
    logic                     r_trigger;
    logic [TIME_BITS-1:0]     r_last_click;
    mcgd_pkg::t_count         r_tally;

    logic                     r_out_valid;
    logic                     r_out_click;
    mcgd_pkg::t_gesture       r_out_gesture;
    mcgd_pkg::t_count         r_out_count;

    logic                     in_button;
    logic                     in_ir;
    logic [ADC_BITS-1:0]      in_flex;
    logic [TIME_BITS-1:0]     in_now;

    logic                     accept;
    logic                     button_click;
    logic [ADC_BITS-1:0]      avg_seed;
    logic [SUM_BITS-1:0]      avg_sum;
    logic [ADC_BITS-1:0]      n_flex_avg;
    logic                     signal_on;
    mcgd_pkg::t_count         n_run;
    logic [TIME_BITS-1:0]     elapsed;
    logic                     debounce_ok;
    logic                     sensor_click;
    logic                     n_trigger;
    logic                     click;
    mcgd_pkg::t_count         tally_inc;
    logic [TIME_BITS-1:0]     n_last_click;
    logic [TIME_BITS-1:0]     quiet;
    logic                     report;
    mcgd_pkg::t_gesture       n_gesture;
    mcgd_pkg::t_count         n_tally;

    assign in_button = s_axis_tdata[0];
    assign in_ir     = s_axis_tdata[1];
    assign in_flex   = s_axis_tdata[2 +: ADC_BITS];
    assign in_now    = s_axis_tdata[2+ADC_BITS +: TIME_BITS];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        button_click = r_button_prev && !in_button;

        avg_seed   = (r_flex_avg == '0) ? in_flex : r_flex_avg;
        avg_sum    = ({2'b00, avg_seed} << 1) + {2'b00, avg_seed} + {2'b00, in_flex};
        n_flex_avg = avg_sum[SUM_BITS-1:2];

        signal_on = !in_ir || (CMP_BITS'(n_flex_avg) > CMP_BITS'(r_flex_threshold));

        if (signal_on) begin
            n_run = (r_run == mcgd_pkg::COUNT_MAX) ? r_run : r_run + 8'd1;
        end else begin
            n_run = '0;
        end

        elapsed     = in_now - r_last_click;
        debounce_ok = elapsed >= {{(TIME_BITS-16){1'b0}}, r_debounce_ms};

        sensor_click = signal_on && !r_trigger && (n_run >= r_sustain_samples) && debounce_ok;

        if (signal_on) begin
            n_trigger = r_trigger || sensor_click;
        end else begin
            n_trigger = r_trigger && !debounce_ok;
        end

        click     = button_click || sensor_click;
        tally_inc = r_tally;
        if (click && (r_tally != mcgd_pkg::COUNT_MAX)) begin
            tally_inc = r_tally + 8'd1;
        end
        n_last_click = click ? in_now : r_last_click;

        // A click on this beat restarts the quiet time at zero.
        quiet  = click ? '0 : elapsed;
        report = (tally_inc != '0) && (quiet >= {{(TIME_BITS-16){1'b0}}, r_window_ms});

        n_gesture = mcgd_pkg::GESTURE_NONE;
        if (report) begin
            n_gesture = (tally_inc >= 8'd4) ? mcgd_pkg::GESTURE_QUAD : tally_inc[2:0];
        end
        n_tally = report ? '0 : tally_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flex_threshold  <= mcgd_pkg::RST_FLEX_THRESHOLD[THR_BITS-1:0];
            r_debounce_ms     <= mcgd_pkg::RST_DEBOUNCE_MS;
            r_window_ms       <= mcgd_pkg::RST_WINDOW_MS;
            r_sustain_samples <= mcgd_pkg::RST_SUSTAIN_SAMPLES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mcgd_pkg::CFG_FLEX_THRESHOLD:  r_flex_threshold  <= i_cfg_wdata[THR_BITS-1:0];
                mcgd_pkg::CFG_DEBOUNCE_MS:     r_debounce_ms     <= i_cfg_wdata;
                mcgd_pkg::CFG_WINDOW_MS:       r_window_ms       <= i_cfg_wdata;
                mcgd_pkg::CFG_SUSTAIN_SAMPLES: r_sustain_samples <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_prev <= 1'b1;
            r_flex_avg    <= '0;
            r_run         <= '0;
            r_trigger     <= 1'b0;
            r_last_click  <= '0;
            r_tally       <= '0;
        end else if (accept) begin
            r_button_prev <= in_button;
            r_flex_avg    <= n_flex_avg;
            r_run         <= n_run;
            r_trigger     <= n_trigger;
            r_last_click  <= n_last_click;
            r_tally       <= n_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_click   <= click;
            r_out_gesture <= n_gesture;
            r_out_count   <= n_tally;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_count, r_out_gesture, r_out_click};

    `MCGD_ASSERT_NEXT(a_accept_gives_result, accept, r_out_valid)
    `MCGD_ASSERT_NOW(a_stall_blocks_input, r_out_valid && !m_axis_tready, !s_axis_tready)
    `MCGD_ASSERT_NOW(a_report_clears_count,
        r_out_valid && (r_out_gesture != mcgd_pkg::GESTURE_NONE), r_out_count == '0)
    `MCGD_ASSERT_NOW(a_gesture_range, r_out_valid, r_out_gesture <= mcgd_pkg::GESTURE_QUAD)

endmodule
